// ----- sv/maze_wall_map_store_macros.svh -----
// Assertion shorthands used by the asserting file of the wall map store.
`ifndef MAZE_WALL_MAP_STORE_MACROS_SVH
`define MAZE_WALL_MAP_STORE_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define MWMS_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define MWMS_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mwms_pkg.sv -----
package mwms_pkg;

    localparam int GRID_SIDE = 16;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COORD_W   = 4;
    localparam int CELL_W    = 8;

    // Wall bits, both nibbles; low nibble known, high nibble assumed.
    localparam logic [CELL_W-1:0] CELL_UNKNOWN = 8'hf0;
    localparam logic [CELL_W-1:0] BORDER_WEST  = 8'hf1;
    localparam logic [CELL_W-1:0] BORDER_EAST  = 8'hf4;
    localparam logic [CELL_W-1:0] BORDER_SOUTH = 8'hf2;
    localparam logic [CELL_W-1:0] BORDER_NORTH = 8'hf8;
    localparam logic [CELL_W-1:0] BOTH_NORTH   = 8'h88;
    localparam logic [CELL_W-1:0] BOTH_SOUTH   = 8'h22;
    localparam logic [CELL_W-1:0] BOTH_EAST    = 8'h44;
    localparam logic [CELL_W-1:0] BOTH_WEST    = 8'h11;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_WRITE  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_CENTER,
        S_WRITE,
        S_READ,
        S_READ_DATA,
        S_NB_RD,
        S_NB_MOD
    } state_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic              clr;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic [CELL_W-1:0] data;
        logic              known;
    } mem_rsp_t;

    function automatic logic in_grid(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        return (int'(x) < GRID_SIDE) && (int'(y) < GRID_SIDE);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_index(logic [COORD_W-1:0] x,
                                                     logic [COORD_W-1:0] y);
        return ADDR_W'(int'(y) * GRID_SIDE + int'(x));
    endfunction

    // Contents of a cell right after a clear.
    function automatic logic [CELL_W-1:0] clear_value(logic [COORD_W-1:0] x,
                                                      logic [COORD_W-1:0] y);
        logic [CELL_W-1:0] v;
        v = CELL_UNKNOWN;
        if (int'(x) == 0)             v = v | BORDER_WEST;
        if (int'(x) == GRID_SIDE - 1) v = v | BORDER_EAST;
        if (int'(y) == 0)             v = v | BORDER_SOUTH;
        if (int'(y) == GRID_SIDE - 1) v = v | BORDER_NORTH;
        return v;
    endfunction

endpackage

// ----- sv/maze_wall_map_store.sv -----
// Channel   Transfer when          Fields
// command   start && !busy         opcode, cell_x, cell_y, heading, wall_bits
// result    done (one cycle)       cell_value
//
// Clear runs in S_CLEAR, raw write in S_WRITE, read in S_READ then S_READ_DATA, update
// in S_CENTER (center write), then per neighbor S_NB_RD (read, or skip outside the
// grid) and S_NB_MOD (write, inside the grid only), all through the single RAM port.
// Busy is high from the cycle after a transfer until done rises; the next command may
// be issued in the cycle of done. Reset and clear empty the per-cell valid bits at
// once, so an unwritten cell reads as its cleared pattern. The receiver cannot stall.
`include "maze_wall_map_store_macros.svh"

module maze_wall_map_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   opcode,
    input  logic [mwms_pkg::COORD_W-1:0] cell_x,
    input  logic [mwms_pkg::COORD_W-1:0] cell_y,
    input  logic [1:0]                   heading,
    input  logic [mwms_pkg::CELL_W-1:0]  wall_bits,
    output logic                         done,
    output logic [mwms_pkg::CELL_W-1:0]  cell_value
);

    mwms_pkg::mem_req_t mem_req;
    mwms_pkg::mem_rsp_t mem_rsp;

    // One valid bit per cell: set on any write, dropped on clear.
    logic [mwms_pkg::CELLS-1:0] valid_reg, valid_next;
    logic                       known_reg;
    logic [mwms_pkg::CELL_W-1:0] ram_rdata;

    always_comb
    begin
        valid_next = valid_reg;
        priority if (mem_req.clr)
        begin
            valid_next = '0;
        end
        else if (mem_req.we)
        begin
            valid_next[mem_req.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            known_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            // Sample validity alongside the RAM read so both land together.
            if (mem_req.re)
            begin
                known_reg <= valid_reg[mem_req.addr];
            end
        end
    end

    assign mem_rsp.data  = ram_rdata;
    assign mem_rsp.known = known_reg;

    mwms_ram #(
        .WIDTH (mwms_pkg::CELL_W),
        .DEPTH (mwms_pkg::CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (ram_rdata)
    );

    mwms_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .heading    (heading),
        .wall_bits  (wall_bits),
        .done       (done),
        .cell_value (cell_value),
        .mem_req    (mem_req),
        .mem_rsp    (mem_rsp)
    );

    `MWMS_CHECK_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "command not taken")
    `MWMS_CHECK(a_done_idle, clk, rst_n, done, !busy, "result while still busy")
    `MWMS_CHECK(a_mem_busy, clk, rst_n, mem_req.we || mem_req.re || mem_req.clr, busy,
        "RAM access while idle")
    `MWMS_CHECK_NEXT(a_clear_empty, clk, rst_n, mem_req.clr, $countones(valid_reg) == 0,
        "valid bits survive clear")

endmodule

// ----- sv/mwms_ram.sv -----
module mwms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/mwms_seq.sv -----
module mwms_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     opcode,
    input  logic [mwms_pkg::COORD_W-1:0]   cell_x,
    input  logic [mwms_pkg::COORD_W-1:0]   cell_y,
    input  logic [1:0]                     heading,
    input  logic [mwms_pkg::CELL_W-1:0]    wall_bits,
    output logic                           done,
    output logic [mwms_pkg::CELL_W-1:0]    cell_value,
    output mwms_pkg::mem_req_t             mem_req,
    input  mwms_pkg::mem_rsp_t             mem_rsp
);

    mwms_pkg::state_t state_reg, state_next;
    mwms_pkg::dir_t   nb_reg, nb_next;
    logic             done_reg, done_next;
    logic [mwms_pkg::CELL_W-1:0]  value_reg, value_next;
    logic [mwms_pkg::COORD_W-1:0] x_reg, y_reg;
    logic [mwms_pkg::CELL_W-1:0]  w_reg;
    logic                         inside_reg;
    logic                         accept;
    logic [3:0]                   sensed;

    logic [mwms_pkg::COORD_W-1:0] nb_x, nb_y;
    logic                         nb_in, nb_present;
    logic [mwms_pkg::CELL_W-1:0]  nb_mask, nb_old;
    logic                         nb_last;
    mwms_pkg::dir_t               nb_succ;

    assign accept  = start && (state_reg == mwms_pkg::S_IDLE);
    assign sensed  = 4'(wall_bits >> heading);
    assign nb_last = (nb_reg == mwms_pkg::DIR_WEST);
    assign nb_succ = mwms_pkg::dir_t'(2'(nb_reg + 2'd1));

    // Neighbor under work: coordinates, whether it exists, and the shared wall.
    always_comb
    begin
        nb_x       = x_reg;
        nb_y       = y_reg;
        nb_in      = 1'b0;
        nb_present = 1'b0;
        nb_mask    = '0;
        unique case (nb_reg)
            mwms_pkg::DIR_NORTH:
            begin
                nb_y       = mwms_pkg::COORD_W'(y_reg + 1'b1);
                nb_in      = int'(y_reg) != mwms_pkg::GRID_SIDE - 1;
                nb_present = |(w_reg & mwms_pkg::BOTH_NORTH);
                nb_mask    = mwms_pkg::BOTH_SOUTH;
            end
            mwms_pkg::DIR_EAST:
            begin
                nb_x       = mwms_pkg::COORD_W'(x_reg + 1'b1);
                nb_in      = int'(x_reg) != mwms_pkg::GRID_SIDE - 1;
                nb_present = |(w_reg & mwms_pkg::BOTH_EAST);
                nb_mask    = mwms_pkg::BOTH_WEST;
            end
            mwms_pkg::DIR_SOUTH:
            begin
                nb_y       = mwms_pkg::COORD_W'(y_reg - 1'b1);
                nb_in      = int'(y_reg) != 0;
                nb_present = |(w_reg & mwms_pkg::BOTH_SOUTH);
                nb_mask    = mwms_pkg::BOTH_NORTH;
            end
            mwms_pkg::DIR_WEST:
            begin
                nb_x       = mwms_pkg::COORD_W'(x_reg - 1'b1);
                nb_in      = int'(x_reg) != 0;
                nb_present = |(w_reg & mwms_pkg::BOTH_WEST);
                nb_mask    = mwms_pkg::BOTH_EAST;
            end
            default:
            begin
                nb_in = 1'b0;
            end
        endcase
        nb_old = mem_rsp.known ? mem_rsp.data : mwms_pkg::clear_value(nb_x, nb_y);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mwms_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (mwms_pkg::op_t'(opcode))
                        mwms_pkg::OP_CLEAR:  state_next = mwms_pkg::S_CLEAR;
                        mwms_pkg::OP_UPDATE: state_next = mwms_pkg::S_CENTER;
                        mwms_pkg::OP_WRITE:  state_next = mwms_pkg::S_WRITE;
                        mwms_pkg::OP_READ:   state_next = mwms_pkg::S_READ;
                        default:             state_next = mwms_pkg::S_IDLE;
                    endcase
                end
            end
            mwms_pkg::S_CLEAR:     state_next = mwms_pkg::S_IDLE;
            mwms_pkg::S_CENTER:
                state_next = inside_reg ? mwms_pkg::S_NB_RD : mwms_pkg::S_IDLE;
            mwms_pkg::S_WRITE:     state_next = mwms_pkg::S_IDLE;
            mwms_pkg::S_READ:
                state_next = inside_reg ? mwms_pkg::S_READ_DATA : mwms_pkg::S_IDLE;
            mwms_pkg::S_READ_DATA: state_next = mwms_pkg::S_IDLE;
            mwms_pkg::S_NB_RD:
            begin
                priority if (nb_in)   state_next = mwms_pkg::S_NB_MOD;
                else if (nb_last)     state_next = mwms_pkg::S_IDLE;
                else                  state_next = mwms_pkg::S_NB_RD;
            end
            mwms_pkg::S_NB_MOD:
                state_next = nb_last ? mwms_pkg::S_IDLE : mwms_pkg::S_NB_RD;
            default:               state_next = mwms_pkg::S_IDLE;
        endcase
    end

    // Memory requests and result.
    always_comb
    begin
        mem_req    = '0;
        done_next  = 1'b0;
        value_next = value_reg;
        nb_next    = nb_reg;
        unique case (state_reg)
            mwms_pkg::S_IDLE:
            begin
                done_next = 1'b0;
            end
            mwms_pkg::S_CLEAR:
            begin
                mem_req.clr = 1'b1;
                done_next   = 1'b1;
                value_next  = inside_reg ? mwms_pkg::clear_value(x_reg, y_reg) : '0;
            end
            mwms_pkg::S_CENTER:
            begin
                nb_next = mwms_pkg::DIR_NORTH;
                if (inside_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.addr  = mwms_pkg::cell_index(x_reg, y_reg);
                    mem_req.wdata = w_reg;
                end
                else
                begin
                    done_next  = 1'b1;
                    value_next = '0;
                end
            end
            mwms_pkg::S_WRITE:
            begin
                mem_req.we    = inside_reg;
                mem_req.addr  = mwms_pkg::cell_index(x_reg, y_reg);
                mem_req.wdata = w_reg;
                done_next     = 1'b1;
                value_next    = inside_reg ? w_reg : '0;
            end
            mwms_pkg::S_READ:
            begin
                mem_req.re   = inside_reg;
                mem_req.addr = mwms_pkg::cell_index(x_reg, y_reg);
                if (!inside_reg)
                begin
                    done_next  = 1'b1;
                    value_next = '0;
                end
            end
            mwms_pkg::S_READ_DATA:
            begin
                done_next  = 1'b1;
                value_next = mem_rsp.known ? mem_rsp.data
                                           : mwms_pkg::clear_value(x_reg, y_reg);
            end
            mwms_pkg::S_NB_RD:
            begin
                mem_req.addr = mwms_pkg::cell_index(nb_x, nb_y);
                if (nb_in)
                begin
                    mem_req.re = 1'b1;
                end
                else
                begin
                    nb_next = nb_succ;
                    if (nb_last)
                    begin
                        done_next  = 1'b1;
                        value_next = w_reg;
                    end
                end
            end
            mwms_pkg::S_NB_MOD:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = mwms_pkg::cell_index(nb_x, nb_y);
                mem_req.wdata = nb_present ? (nb_old | nb_mask) : (nb_old & ~nb_mask);
                nb_next       = nb_succ;
                if (nb_last)
                begin
                    done_next  = 1'b1;
                    value_next = w_reg;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mwms_pkg::S_IDLE;
            nb_reg    <= mwms_pkg::DIR_NORTH;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nb_reg    <= nb_next;
            done_reg  <= done_next;
        end
    end

    // Hold the operands of the accepted command, and register the result value.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (accept)
        begin
            x_reg      <= cell_x;
            y_reg      <= cell_y;
            inside_reg <= mwms_pkg::in_grid(cell_x, cell_y);
            w_reg      <= (mwms_pkg::op_t'(opcode) == mwms_pkg::OP_UPDATE)
                          ? {sensed, sensed} : wall_bits;
        end
    end

    assign busy       = (state_reg != mwms_pkg::S_IDLE);
    assign done       = done_reg;
    assign cell_value = value_reg;

endmodule

// ----- dv/maze_wall_map_store_tb.sv -----
`timescale 1ns / 100ps

module maze_wall_map_store_tb;

    localparam int SIDE          = mwms_pkg::GRID_SIDE;
    localparam int LAST          = SIDE - 1;
    localparam int STALL_LIMIT   = 300;  // cycles with neither a transfer nor a result
    localparam int DRAIN_CYCLES  = 16;
    localparam int PHASE_ITEMS   = 175;
    localparam int MAX_GAP       = 12;
    localparam int DIRECTED_ROWS = 24;

    // One command row. Where lit_ok is set, lit is the cell byte read straight off the
    // map rules; otherwise the expected byte comes from the wall map mirror below.
    typedef struct packed {
        mwms_pkg::op_t op;
        logic [3:0]    x;
        logic [3:0]    y;
        logic [1:0]    hd;
        logic [7:0]    bits;
        logic          lit_ok;
        logic [7:0]    lit;
    } map_cmd_t;

    typedef struct {
        mwms_pkg::op_t op;
        logic [3:0]    x;
        logic [3:0]    y;
        logic [7:0]    value;
    } cell_due_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] opcode;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [1:0] heading;
    logic [7:0] wall_bits;
    logic       done;
    logic [7:0] cell_value;

    // Mirror of the wall RAM, indexed [row][column].
    logic [7:0] wall_map [SIDE][SIDE];
    cell_due_t  cell_value_due [$];

    int errors;
    int results_seen;
    int quiet_cycles;
    int op_count [4];

    // Directed commands: reset pattern at the corners and inside, raw writes at both
    // byte extremes, updates on every heading and in all four corners, a sensed
    // pattern whose set bits all fall above the nibble, and clears from inner and corner cells.
    map_cmd_t directed_cmds [DIRECTED_ROWS] = '{
        '{mwms_pkg::OP_READ,   4'd0,  4'd0,  2'd0, 8'h00, 1'b1, 8'hf3},
        '{mwms_pkg::OP_READ,   4'd15, 4'd15, 2'd0, 8'h00, 1'b1, 8'hfc},
        '{mwms_pkg::OP_READ,   4'd15, 4'd0,  2'd0, 8'h00, 1'b1, 8'hf6},
        '{mwms_pkg::OP_READ,   4'd0,  4'd15, 2'd0, 8'h00, 1'b1, 8'hf9},
        '{mwms_pkg::OP_READ,   4'd6,  4'd9,  2'd0, 8'h00, 1'b1, 8'hf0},
        '{mwms_pkg::OP_WRITE,  4'd3,  4'd4,  2'd0, 8'hff, 1'b1, 8'hff},
        '{mwms_pkg::OP_WRITE,  4'd3,  4'd4,  2'd0, 8'h00, 1'b1, 8'h00},
        '{mwms_pkg::OP_READ,   4'd3,  4'd4,  2'd0, 8'h00, 1'b1, 8'h00},
        '{mwms_pkg::OP_UPDATE, 4'd0,  4'd0,  2'd0, 8'hff, 1'b1, 8'hff},
        '{mwms_pkg::OP_READ,   4'd1,  4'd0,  2'd0, 8'h00, 1'b0, 8'h00},
        '{mwms_pkg::OP_READ,   4'd0,  4'd1,  2'd0, 8'h00, 1'b0, 8'h00},
        '{mwms_pkg::OP_UPDATE, 4'd15, 4'd15, 2'd3, 8'h80, 1'b1, 8'h00},
        '{mwms_pkg::OP_READ,   4'd14, 4'd15, 2'd0, 8'h00, 1'b0, 8'h00},
        '{mwms_pkg::OP_READ,   4'd15, 4'd14, 2'd0, 8'h00, 1'b0, 8'h00},
        '{mwms_pkg::OP_UPDATE, 4'd7,  4'd7,  2'd1, 8'h1e, 1'b1, 8'hff},
        '{mwms_pkg::OP_UPDATE, 4'd7,  4'd8,  2'd2, 8'haa, 1'b0, 8'h00},
        '{mwms_pkg::OP_READ,   4'd7,  4'd7,  2'd0, 8'h00, 1'b0, 8'h00},
        '{mwms_pkg::OP_UPDATE, 4'd15, 4'd0,  2'd0, 8'h05, 1'b0, 8'h00},
        '{mwms_pkg::OP_UPDATE, 4'd0,  4'd15, 2'd0, 8'h0a, 1'b0, 8'h00},
        '{mwms_pkg::OP_READ,   4'd7,  4'd6,  2'd0, 8'h00, 1'b0, 8'h00},
        '{mwms_pkg::OP_WRITE,  4'd9,  4'd9,  2'd0, 8'ha5, 1'b1, 8'ha5},
        '{mwms_pkg::OP_CLEAR,  4'd9,  4'd9,  2'd0, 8'hff, 1'b1, 8'hf0},
        '{mwms_pkg::OP_READ,   4'd0,  4'd0,  2'd0, 8'h00, 1'b1, 8'hf3},
        '{mwms_pkg::OP_CLEAR,  4'd15, 4'd0,  2'd3, 8'h00, 1'b1, 8'hf6}
    };

    maze_wall_map_store DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .heading    (heading),
        .wall_bits  (wall_bits),
        .done       (done),
        .cell_value (cell_value)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Rebuild the unknown maze: every cell assumes all four walls, the outer
    // border is known on its outward side.
    function automatic void map_rebuild();
        logic [7:0] v;
        for (int y = 0; y < SIDE; y++)
            for (int x = 0; x < SIDE; x++)
            begin
                v = mwms_pkg::CELL_UNKNOWN;
                if (x == 0)    v = v | mwms_pkg::BORDER_WEST;
                if (x == LAST) v = v | mwms_pkg::BORDER_EAST;
                if (y == 0)    v = v | mwms_pkg::BORDER_SOUTH;
                if (y == LAST) v = v | mwms_pkg::BORDER_NORTH;
                wall_map[y][x] = v;
            end
    endfunction

    // Set or clear the shared wall in a neighbor, both nibbles at once.
    function automatic void neighbor_agree(int x, int y, logic present, logic [7:0] mask);
        if (present)
            wall_map[y][x] = wall_map[y][x] | mask;
        else
            wall_map[y][x] = wall_map[y][x] & ~mask;
    endfunction

    function automatic void map_sense(int x, int y, logic [1:0] hd, logic [7:0] bits);
        logic [3:0] seen;
        logic [7:0] w;
        // Shift by heading, keep the low nibble, mark it both known and assumed.
        seen = 4'(bits >> hd);
        w    = {seen, seen};
        wall_map[y][x] = w;
        if (y != LAST)
            neighbor_agree(x, y + 1, |(w & mwms_pkg::BOTH_NORTH), mwms_pkg::BOTH_SOUTH);
        if (x != LAST)
            neighbor_agree(x + 1, y, |(w & mwms_pkg::BOTH_EAST), mwms_pkg::BOTH_WEST);
        if (y != 0)
            neighbor_agree(x, y - 1, |(w & mwms_pkg::BOTH_SOUTH), mwms_pkg::BOTH_NORTH);
        if (x != 0)
            neighbor_agree(x - 1, y, |(w & mwms_pkg::BOTH_WEST), mwms_pkg::BOTH_EAST);
    endfunction

    // Apply one command to the mirror and return the addressed byte afterwards.
    // A 4-bit coordinate never leaves a 16-wide grid, so every address is inside.
    function automatic logic [7:0] map_apply(map_cmd_t c);
        case (c.op)
            mwms_pkg::OP_CLEAR:  map_rebuild();
            mwms_pkg::OP_UPDATE: map_sense(int'(c.x), int'(c.y), c.hd, c.bits);
            mwms_pkg::OP_WRITE:  wall_map[c.y][c.x] = c.bits;
            default: ;
        endcase
        return wall_map[c.y][c.x];
    endfunction

    // Present a command and hold it until the transfer; start stays high on return
    // so a back-to-back command can follow in the same step.
    task automatic send_cmd(map_cmd_t c);
        cell_due_t due;
        opcode    <= c.op;
        cell_x    <= c.x;
        cell_y    <= c.y;
        heading   <= c.hd;
        wall_bits <= c.bits;
        start     <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        due.op    = c.op;
        due.x     = c.x;
        due.y     = c.y;
        due.value = map_apply(c);
        if (c.lit_ok)
            due.value = c.lit;
        cell_value_due.push_back(due);
        op_count[c.op]++;
    endtask

    // Drop start for a random gap in pct out of a hundred commands.
    task automatic sender_gap(int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
    endtask

    function automatic logic [3:0] clamp_step(int v);
        if (v < 0)    return 4'd0;
        if (v > LAST) return 4'(LAST);
        return 4'(v);
    endfunction

    // Result side: every done is one transfer, checked against the oldest
    // expectation. The watchdog counts cycles in which nothing moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                results_seen++;
                if (cell_value_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result %h with no command outstanding", $realtime,
                             cell_value);
                end
                else if (cell_value !== cell_value_due[0].value)
                begin
                    errors++;
                    $display("%0t: cell_value mismatch, %s at (%0d,%0d): expected %h, got %h",
                             $realtime, cell_value_due[0].op.name(), cell_value_due[0].x,
                             cell_value_due[0].y, cell_value_due[0].value, cell_value);
                    void'(cell_value_due.pop_front());
                end
                else
                    void'(cell_value_due.pop_front());
            end
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $realtime, STALL_LIMIT, cell_value_due.size());
                $display("maze_wall_map_store_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        map_cmd_t c;
        int       pick;
        int       walk_x;
        int       walk_y;
        int       idle_pct [4];

        errors       = 0;
        results_seen = 0;
        quiet_cycles = 0;
        op_count     = '{default: 0};
        idle_pct     = '{0, 74, 0, 30};
        walk_x       = 0;
        walk_y       = 0;

        // Drive every input known before reset lifts.
        rst_n     = 1'b0;
        start     = 1'b0;
        opcode    = mwms_pkg::OP_READ;
        cell_x    = '0;
        cell_y    = '0;
        heading   = '0;
        wall_bits = '0;
        map_rebuild();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, back to back.
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_cmd(directed_cmds[i]);

        // Random commands. The largest share are updates along a random walk, like a robot
        // exploring cell by cell, with reads of the cells around it, so neighbor
        // fixes pile up on each other. Raw writes and rare clears add noise.
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                c      = '0;
                c.hd   = 2'($urandom_range(3));
                c.bits = 8'($urandom_range(255));
                pick   = $urandom_range(99);
                case ($urandom_range(3))
                    0: walk_x = clamp_step(walk_x + 1);
                    1: walk_x = clamp_step(walk_x - 1);
                    2: walk_y = clamp_step(walk_y + 1);
                    default: walk_y = clamp_step(walk_y - 1);
                endcase
                if ($urandom_range(9) == 0)
                begin
                    // jump, often onto the border
                    walk_x = $urandom_range(3) == 0 ? LAST * $urandom_range(1) :
                                                      $urandom_range(LAST);
                    walk_y = $urandom_range(3) == 0 ? LAST * $urandom_range(1) :
                                                      $urandom_range(LAST);
                end
                c.x = 4'(walk_x);
                c.y = 4'(walk_y);
                if (pick < 3)
                    c.op = mwms_pkg::OP_CLEAR;
                else if (pick < 50)
                    c.op = mwms_pkg::OP_UPDATE;
                else if (pick < 68)
                begin
                    c.op = mwms_pkg::OP_WRITE;
                    if ($urandom_range(1))
                    begin
                        c.x = 4'($urandom_range(LAST));
                        c.y = 4'($urandom_range(LAST));
                    end
                end
                else
                begin
                    c.op = mwms_pkg::OP_READ;
                    c.x  = clamp_step(walk_x + $urandom_range(2) - 1);
                    c.y  = clamp_step(walk_y + $urandom_range(2) - 1);
                end
                send_cmd(c);
                sender_gap(idle_pct[ph]);
            end
        end
        start <= 1'b0;

        // Drain: the watchdog bounds this wait.
        while (cell_value_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("maze_wall_map_store_tb: %0d clear, %0d update, %0d write, %0d read commands",
                 op_count[mwms_pkg::OP_CLEAR], op_count[mwms_pkg::OP_UPDATE],
                 op_count[mwms_pkg::OP_WRITE], op_count[mwms_pkg::OP_READ]);
        $display("maze_wall_map_store_tb: %0d results checked over four sender idle phases",
                 results_seen);
        if (errors == 0)
            $display("maze_wall_map_store_tb: clean");
        else
            $display("maze_wall_map_store_tb: errors");
        $finish;
    end

endmodule

// ----- maze_wall_map_store.f -----
+incdir+sv
sv/mwms_pkg.sv
sv/mwms_ram.sv
sv/mwms_seq.sv
sv/maze_wall_map_store.sv
dv/maze_wall_map_store_tb.sv
